@@ rtl/core/aligned_block_finder_top_defines.svh @@
// Assertion macros for the aligned block finder.
`ifndef ALIGNED_BLOCK_FINDER_TOP_DEFINES_SVH
`define ALIGNED_BLOCK_FINDER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define ABF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ABF_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ABF_ASSERT(lbl, clk, rst, prop, msg)
`define ABF_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/core/abf_pkg.sv @@
// Shared types and constants of the aligned block finder.
`default_nettype none
package abf_pkg;
   localparam logic [31:0] NOT_FOUND  = 32'hFFFF_FFFF;
   localparam logic [1:0]  ACT_CLEAR  = 2'd0;
   localparam logic [1:0]  ACT_APPEND = 2'd1;
   localparam logic [1:0]  ACT_QUERY  = 2'd2;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] rem;
   } div_rsp_type;
endpackage
`default_nettype wire

@@ rtl/core/abf_if.sv @@
// Request and response channel interfaces of the aligned block finder.
`default_nettype none
interface abf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [63:0] region_base;
   logic [63:0] region_length;
   logic [31:0] query_addr;
   logic        query_above;
   logic [31:0] query_len;
   logic [31:0] query_align;
   modport source (output valid, action, region_base, region_length, query_addr,
                   query_above, query_len, query_align, input ready);
   modport sink (input valid, action, region_base, region_length, query_addr,
                 query_above, query_len, query_align, output ready);
endinterface

interface abf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] block_addr;
   modport source (output valid, block_addr, input ready);
   modport sink (input valid, block_addr, output ready);
endinterface
`default_nettype wire

@@ rtl/core/abf_div.sv @@
// Bit-serial restoring divider producing the remainder, one bit per cycle.
`default_nettype none
`include "aligned_block_finder_top_defines.svh"
module abf_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire abf_pkg::div_req_type req_i,
   output abf_pkg::div_rsp_type      rsp_o
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [32:0] trial;
   logic [32:0] diff;

   assign trial = {rem_ff, dvd_ff[31]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      if (req_i.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd31;
         rem_in  = '0;
         dvd_in  = req_i.dividend;
         dvs_in  = req_i.divisor;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, dvs_ff}) ? diff[31:0] : trial[31:0];
         dvd_in = {dvd_ff[30:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign rsp_o.busy = busy_ff;
   assign rsp_o.done = done_ff;
   assign rsp_o.rem  = rem_ff;

   `ABF_ASSERT(a_done_idle, clock, reset, done_ff |-> !busy_ff, "done while busy")
   `ABF_ASSERT(a_start_busy, clock, reset, req_i.start |=> busy_ff, "start not taken")
   `ABF_ASSERT(a_rem_range, clock, reset, busy_ff |-> (rem_ff < dvs_ff), "partial rem too big")
endmodule
`default_nettype wire

@@ rtl/core/aligned_block_finder_top.sv @@
// Top level of the aligned block finder: region table, sequencer, shared divider.
// Usage:
//  req_bus carries one beat per item: clear table, append a region, or query.
//  Clear and append are taken while the sequencer is idle and give no response.
//  A query gives one rsp_bus beat holding block_addr: all ones when none found,
//  but zero for a below query on an empty table. A query rounds the reference
//  address on the shared bit-serial divider, starts the scan, then for each
//  region held reads, evaluates, runs a remainder pass and compares. An
//  alignment of 0 or 1 skips the divider; a region that is too small or starts
//  at or above 0xFFFF_FFFF skips the remainder pass and the compare.
//  req_bus.ready is high only while the sequencer is idle; one item at a time.
//  The result sits in an output register; a new item is taken while it waits.
//  A query that finishes while the previous result is still stalled waits for
//  rsp_bus.ready before loading its result.
//  Reset empties the table and drops any pending result; no clearing pass.
`default_nettype none
`include "aligned_block_finder_top_defines.svh"
module aligned_block_finder_top #(
   parameter int MAX_REGIONS = 32
) (
   input wire logic  clock,
   input wire logic  reset,
   abf_req_if.sink   req_bus,
   abf_rsp_if.source rsp_bus
);
   localparam int CW = $clog2(MAX_REGIONS + 1);
   localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_TGT   = 3'd1;
   localparam logic [2:0] S_SCAN0 = 3'd2;
   localparam logic [2:0] S_RD    = 3'd3;
   localparam logic [2:0] S_EVAL  = 3'd4;
   localparam logic [2:0] S_CAND  = 3'd5;
   localparam logic [2:0] S_CMP   = 3'd6;
   localparam logic [2:0] S_RES   = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [31:0]   addr_ff, addr_in;
   logic          above_ff, above_in;
   logic [31:0]   size_ff, size_in;
   logic [31:0]   al_ff, al_in;
   logic          al1_ff, al1_in;
   logic [31:0]   target_ff, target_in;
   logic [31:0]   best_ff, best_in;
   logic [31:0]   base_ff, base_in;
   logic [31:0]   end_ff, end_in;
   logic [31:0]   shift_ff, shift_in;
   logic [31:0]   cand_ff, cand_in;
   logic [31:0]   res_ff, res_in;
   logic          out_valid_ff, out_valid_in;
   logic [31:0]   out_addr_ff, out_addr_in;
   logic [127:0]  rd_data_ff;
   logic [127:0]  mem [MAX_REGIONS];

   abf_pkg::div_req_type div_req;
   abf_pkg::div_rsp_type div_rsp;

   logic        fire;
   logic        wr_en;
   logic        q_inv;
   logic [31:0] q_ref;
   logic        q_al1;
   logic [63:0] rd_start;
   logic [63:0] rd_len;
   logic [63:0] rd_sum;
   logic [31:0] e_span;
   logic [31:0] e_end;
   logic [31:0] e_low;
   logic [31:0] e_shift;
   logic        e_skip;
   logic [31:0] c_room;
   logic        c_in;
   logic        c_hit;
   logic        c_take;
   logic        last;
   logic [31:0] fin_val;
   logic [31:0] rnd_val;

   abf_div u_div (
      .clock (clock),
      .reset (reset),
      .req_i (div_req),
      .rsp_o (div_rsp)
   );

   assign req_bus.ready      = (state_ff == S_IDLE);
   assign fire               = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.block_addr = out_addr_ff;

   assign q_inv = (req_bus.query_len == 32'd0)
                  || (req_bus.query_above && ((req_bus.query_addr == abf_pkg::NOT_FOUND)
                      || ((req_bus.query_addr + req_bus.query_len) < req_bus.query_addr)))
                  || (!req_bus.query_above && ((req_bus.query_addr == 32'd0)
                      || (req_bus.query_addr < req_bus.query_len)));
   assign q_ref = req_bus.query_above ? req_bus.query_addr
                                      : (req_bus.query_addr - req_bus.query_len);
   assign q_al1 = (req_bus.query_align <= 32'd1);

   assign rd_start = rd_data_ff[127:64];
   assign rd_len   = rd_data_ff[63:0];
   assign rd_sum   = rd_start + rd_len;
   assign e_span   = (rd_sum > 64'h0000_0000_FFFF_FFFF) ? (32'hFFFF_FFFF - rd_start[31:0])
                                                        : rd_len[31:0];
   assign e_end    = rd_start[31:0] + e_span;
   assign e_low    = e_end - size_ff;
   assign e_shift  = above_ff ? rd_start[31:0] : ((e_low >= target_ff) ? target_ff : e_low);
   assign e_skip   = (rd_start >= 64'h0000_0000_FFFF_FFFF) || (e_span < size_ff);

   assign c_room = end_ff - cand_ff;
   assign c_in   = (cand_ff >= base_ff) && (cand_ff < end_ff);
   assign c_hit  = (base_ff <= target_ff) && (end_ff > (target_ff + size_ff));
   assign c_take = (c_room >= size_ff)
                   && (above_ff ? ((cand_ff >= addr_ff) && (cand_ff < best_ff))
                                : ((cand_ff < addr_ff) && (cand_ff > best_ff)));

   assign last    = ((idx_ff + CW'(1)) == count_ff);
   assign fin_val = (above_ff || (best_ff != 32'd0)) ? best_ff : abf_pkg::NOT_FOUND;
   assign rnd_val = (div_rsp.rem == 32'd0) ? shift_ff
                    : (shift_ff - div_rsp.rem + (above_ff ? al_ff : 32'd0));

   assign wr_en = fire && (req_bus.action == abf_pkg::ACT_APPEND)
                  && (count_ff < CW'(MAX_REGIONS));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      addr_in      = addr_ff;
      above_in     = above_ff;
      size_in      = size_ff;
      al_in        = al_ff;
      al1_in       = al1_ff;
      target_in    = target_ff;
      best_in      = best_ff;
      base_in      = base_ff;
      end_in       = end_ff;
      shift_in     = shift_ff;
      cand_in      = cand_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_addr_in  = out_addr_ff;
      div_req.start    = 1'b0;
      div_req.dividend = shift_ff;
      div_req.divisor  = al_ff;
      case (state_ff)
         S_IDLE: begin
            if (fire) begin
               case (req_bus.action)
                  abf_pkg::ACT_CLEAR: begin
                     count_in = '0;
                  end
                  abf_pkg::ACT_APPEND: begin
                     if (wr_en) begin
                        count_in = count_ff + CW'(1);
                     end
                  end
                  abf_pkg::ACT_QUERY: begin
                     addr_in  = req_bus.query_addr;
                     above_in = req_bus.query_above;
                     size_in  = req_bus.query_len;
                     al_in    = req_bus.query_align;
                     al1_in   = q_al1;
                     shift_in = q_ref;
                     best_in  = req_bus.query_above ? abf_pkg::NOT_FOUND : 32'd0;
                     if (q_inv) begin
                        res_in   = abf_pkg::NOT_FOUND;
                        state_in = S_RES;
                     end else if (q_al1) begin
                        target_in = q_ref;
                        state_in  = S_SCAN0;
                     end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = q_ref;
                        div_req.divisor  = req_bus.query_align;
                        state_in         = S_TGT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_TGT: begin
            if (div_rsp.done) begin
               target_in = rnd_val;
               state_in  = S_SCAN0;
            end
         end
         S_SCAN0: begin
            idx_in = '0;
            if (count_ff == '0) begin
               res_in   = best_ff;
               state_in = S_RES;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            base_in  = rd_start[31:0];
            end_in   = e_end;
            shift_in = e_shift;
            cand_in  = e_shift;
            if (e_skip) begin
               if (last) begin
                  res_in   = fin_val;
                  state_in = S_RES;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_RD;
               end
            end else if (al1_ff) begin
               state_in = S_CMP;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = e_shift;
               state_in         = S_CAND;
            end
         end
         S_CAND: begin
            if (div_rsp.done) begin
               cand_in  = rnd_val;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (c_in && c_hit) begin
               res_in   = target_ff;
               state_in = S_RES;
            end else begin
               if (c_in && c_take) begin
                  best_in = cand_ff;
               end
               if (last) begin
                  res_in   = (c_in && c_take)
                             ? ((above_ff || (cand_ff != 32'd0)) ? cand_ff : abf_pkg::NOT_FOUND)
                             : fin_val;
                  state_in = S_RES;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_RD;
               end
            end
         end
         S_RES: begin
            if (!out_valid_ff || rsp_bus.ready) begin
               out_valid_in = 1'b1;
               out_addr_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      addr_ff     <= addr_in;
      above_ff    <= above_in;
      size_ff     <= size_in;
      al_ff       <= al_in;
      al1_ff      <= al1_in;
      target_ff   <= target_in;
      best_ff     <= best_in;
      base_ff     <= base_in;
      end_ff      <= end_in;
      shift_ff    <= shift_in;
      cand_ff     <= cand_in;
      res_ff      <= res_in;
      out_addr_ff <= out_addr_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IW-1:0]] <= {req_bus.region_base, req_bus.region_length};
      end
      if (state_ff == S_RD) begin
         rd_data_ff <= mem[idx_ff[IW-1:0]];
      end
   end

   `ABF_ASSERT_NR(a_reset_idle, clock,
      reset |=> (state_ff == S_IDLE) && !out_valid_ff, "reset state")
   `ABF_ASSERT(a_count_max, clock, reset, count_ff <= CW'(MAX_REGIONS), "table overfull")
   `ABF_ASSERT(a_rd_idx, clock, reset, (state_ff == S_RD) |-> (idx_ff < count_ff), "read past table")
   `ABF_ASSERT(a_div_wait, clock, reset,
      ((state_ff == S_TGT) || (state_ff == S_CAND)) |-> (div_rsp.busy || div_rsp.done),
      "divider idle in wait")
endmodule
`default_nettype wire
